>>> src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define VPFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vpfa assertion failed");

// Implication from one clock edge to the next.
`define VPFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vpfa assertion failed");

`endif

>>> src/vpfa_pkg.sv
// Types and constants of the video payload frame assembler.
// No dependencies; used by the top level and its checker.
package vpfa_pkg;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_XFER_FAIL = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_ERR_SKIP  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_BULK_MODE   = 3'd0,
    REG_MAX_PAYLOAD = 3'd1,
    REG_REQ_SIZE    = 3'd2,
    REG_MAX_FRAME   = 3'd3,
    REG_RING_BYTES  = 3'd4
  } cfg_reg_e;

  localparam int unsigned PADDR_W = 5;

  localparam logic [7:0] HDR_FID_BIT = 8'd0;
  localparam logic [7:0] HDR_ERR_BIT = 8'd6;

endpackage

>>> src/video_payload_frame_assembler.sv
// Video payload frame assembler: header parsing, frame tracking and ring slot placement.
// Depends on vpfa_pkg.
//
// Takes one completed camera transfer per cycle and returns one result per transfer. An
// accepted transfer sits in an input register, is evaluated by a single pass of compare and
// add logic that also updates the frame state, and lands in a result register, where it is
// valid until taken; a stalled result keeps the transfer in the input register. A new
// transfer is taken every cycle as long as the result side keeps up.
// The input register keeps accepting while a finished result waits; backpressure reaches
// in_ready_o only when both registers are full. Configuration registers sit on a small
// APB-style port at byte addresses 0, 4, 8, 12 and 16 and are to be written only while no
// transfer is in flight.
module video_payload_frame_assembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vpfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Transfer input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          xfer_ok_i,
  input  logic [23:0]                   actual_len_i,
  input  logic [7:0]                    hdr_len_i,
  input  logic [7:0]                    hdr_info_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [31:0]                   write_offset_o,
  output logic [23:0]                   write_length_o,
  output logic [7:0]                    data_skip_o,
  output logic                          frame_closed_o,
  output logic                          closed_had_error_o,
  output logic [31:0]                   frame_number_o
);
  import vpfa_pkg::*;

  // Configuration registers
  logic        bulk_mode_q;
  logic [31:0] max_payload_q;
  logic [23:0] req_size_q;
  logic [23:0] max_frame_q;
  logic [31:0] ring_bytes_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_sel;

  // Frame state
  logic        fid_valid_q, fid_valid_d;
  logic        cur_fid_q, cur_fid_d;
  logic        frame_err_q, frame_err_d;
  logic [23:0] frame_fill_q, frame_fill_d;
  logic [31:0] slot_offset_q, slot_offset_d;
  logic [31:0] frames_seen_q, frames_seen_d;
  logic [31:0] bulk_count_q, bulk_count_d;

  // Input register
  logic        in_vld_q;
  logic        ok_q;
  logic [23:0] actual_q;
  logic [7:0]  hlen_q;
  logic [7:0]  info_q;

  // Result register
  logic        out_vld_q;
  status_e     status_q, status_d;
  logic [31:0] wr_off_q, wr_off_d;
  logic [23:0] wr_len_q, wr_len_d;
  logic [7:0]  skip_q, skip_d;
  logic        closed_q, closed_d;
  logic        closed_err_q, closed_err_d;

  logic advance;
  logic process;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bulk_mode_q   <= 1'b0;
      max_payload_q <= '0;
      req_size_q    <= '0;
      max_frame_q   <= '0;
      ring_bytes_q  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_BULK_MODE:   bulk_mode_q   <= pwdata[0];
        REG_MAX_PAYLOAD: max_payload_q <= pwdata;
        REG_REQ_SIZE:    req_size_q    <= pwdata[23:0];
        REG_MAX_FRAME:   max_frame_q   <= pwdata[23:0];
        REG_RING_BYTES:  ring_bytes_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_BULK_MODE:   prdata = {31'd0, bulk_mode_q};
      REG_MAX_PAYLOAD: prdata = max_payload_q;
      REG_REQ_SIZE:    prdata = {8'd0, req_size_q};
      REG_MAX_FRAME:   prdata = {8'd0, max_frame_q};
      REG_RING_BYTES:  prdata = ring_bytes_q;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  assign advance    = !out_vld_q || out_ready_i;
  assign process    = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (process) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ok_q     <= xfer_ok_i;
      actual_q <= actual_len_i;
      hlen_q   <= hdr_len_i;
      info_q   <= hdr_info_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Transfer evaluation
  // ---------------------------------------------------------------------------
  always_comb begin
    logic        hdr_parse;
    logic        bad_hdr;
    logic        hdr_good;
    logic        fid;
    logic        new_frame;
    logic        err_now;
    logic [7:0]  hdr_skip;
    logic [23:0] fill_base;
    logic [31:0] slot_base;
    logic [32:0] slot_sum;
    logic [32:0] slot_wrap;
    logic [23:0] data_len;
    logic [24:0] fill_sum;
    logic [31:0] bulk_sum;

    fid_valid_d   = fid_valid_q;
    cur_fid_d     = cur_fid_q;
    frame_err_d   = frame_err_q;
    frame_fill_d  = frame_fill_q;
    slot_offset_d = slot_offset_q;
    frames_seen_d = frames_seen_q;
    bulk_count_d  = bulk_count_q;

    status_d     = ST_DATA;
    wr_off_d     = '0;
    wr_len_d     = '0;
    skip_d       = '0;
    closed_d     = 1'b0;
    closed_err_d = 1'b0;

    // Header is parsed on every isochronous transfer and at the start of a bulk payload.
    hdr_parse = !bulk_mode_q || (bulk_count_q == '0);
    bad_hdr   = hdr_parse && ((actual_q < 24'd2) || ({16'd0, hlen_q} > actual_q));
    hdr_good  = hdr_parse && !bad_hdr;
    fid       = info_q[HDR_FID_BIT[2:0]];
    new_frame = hdr_good && (!fid_valid_q || (cur_fid_q != fid));

    // A frame closed without error moves the ring slot on by one frame size.
    slot_sum  = {1'b0, slot_offset_q} + {9'd0, max_frame_q};
    slot_wrap = (slot_sum >= {1'b0, ring_bytes_q}) ? (slot_sum - {1'b0, ring_bytes_q})
                                                   : slot_sum;
    slot_base = (new_frame && fid_valid_q && !frame_err_q) ? slot_wrap[31:0] : slot_offset_q;
    fill_base = new_frame ? 24'd0 : frame_fill_q;

    err_now   = (new_frame ? 1'b0 : frame_err_q) || (hdr_good && info_q[HDR_ERR_BIT[2:0]]);
    hdr_skip  = (hdr_good && !info_q[HDR_ERR_BIT[2:0]]) ? hlen_q : 8'd0;
    data_len  = actual_q - {16'd0, hdr_skip};
    fill_sum  = {1'b0, fill_base} + {1'b0, data_len};
    bulk_sum  = bulk_count_q + {8'd0, actual_q};

    if (!ok_q) begin
      status_d = ST_XFER_FAIL;
    end else if (actual_q == '0) begin
      status_d = ST_EMPTY;
    end else if (bad_hdr) begin
      status_d = ST_BAD_HDR;
    end else begin
      closed_d     = new_frame && fid_valid_q;
      closed_err_d = new_frame && fid_valid_q && frame_err_q;
      if (new_frame) begin
        fid_valid_d   = 1'b1;
        cur_fid_d     = fid;
        frames_seen_d = frames_seen_q + 32'd1;
      end
      slot_offset_d = slot_base;
      frame_fill_d  = fill_base;
      frame_err_d   = err_now;

      if (bulk_mode_q) begin
        if ((bulk_sum >= max_payload_q) || (actual_q < req_size_q)) begin
          bulk_count_d = '0;
        end else begin
          bulk_count_d = bulk_sum;
        end
      end

      if (err_now) begin
        status_d = ST_ERR_SKIP;
      end else if (fill_sum > {1'b0, max_frame_q}) begin
        status_d    = ST_OVERFLOW;
        frame_err_d = 1'b1;
      end else begin
        status_d     = ST_DATA;
        wr_off_d     = slot_base + {8'd0, fill_base};
        wr_len_d     = data_len;
        skip_d       = hdr_skip;
        frame_fill_d = fill_sum[23:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fid_valid_q   <= 1'b0;
      cur_fid_q     <= 1'b0;
      frame_err_q   <= 1'b0;
      frame_fill_q  <= '0;
      slot_offset_q <= '0;
      frames_seen_q <= '0;
      bulk_count_q  <= '0;
    end else if (process) begin
      fid_valid_q   <= fid_valid_d;
      cur_fid_q     <= cur_fid_d;
      frame_err_q   <= frame_err_d;
      frame_fill_q  <= frame_fill_d;
      slot_offset_q <= slot_offset_d;
      frames_seen_q <= frames_seen_d;
      bulk_count_q  <= bulk_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      status_q     <= status_d;
      wr_off_q     <= wr_off_d;
      wr_len_q     <= wr_len_d;
      skip_q       <= skip_d;
      closed_q     <= closed_d;
      closed_err_q <= closed_err_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign status_o           = status_q;
  assign write_offset_o     = wr_off_q;
  assign write_length_o     = wr_len_q;
  assign data_skip_o        = skip_q;
  assign frame_closed_o     = closed_q;
  assign closed_had_error_o = closed_err_q;
  // The frame count lives in the state, so it is taken right after the update.
  assign frame_number_o     = frames_seen_q;

endmodule

>>> src/vpfa_checker.sv
// Port-level checker for the video payload frame assembler, bound to the top level.
// Depends on vpfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vpfa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [vpfa_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                  pwdata,
  input logic [31:0]                  prdata,
  input logic                         pready,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         xfer_ok_i,
  input logic [23:0]                  actual_len_i,
  input logic [7:0]                   hdr_len_i,
  input logic [7:0]                   hdr_info_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [2:0]                   status_o,
  input logic [31:0]                  write_offset_o,
  input logic [23:0]                  write_length_o,
  input logic [7:0]                   data_skip_o,
  input logic                         frame_closed_o,
  input logic                         closed_had_error_o,
  input logic [31:0]                  frame_number_o
);
  import vpfa_pkg::*;

  // Only a transfer that wrote data carries a placement.
  `VPFA_ASSERT_NOW(a_no_write_unless_data, out_valid_o && (status_o != ST_DATA), (write_offset_o == '0) && (write_length_o == '0) && (data_skip_o == '0))

  // An error flag is reported only for a frame that was actually closed.
  `VPFA_ASSERT_NOW(a_err_needs_close, out_valid_o && closed_had_error_o, frame_closed_o)

  // Failed, empty and badly headed transfers never touch frame tracking.
  `VPFA_ASSERT_NOW(a_reject_no_close, out_valid_o && ((status_o == ST_XFER_FAIL) || (status_o == ST_EMPTY) || (status_o == ST_BAD_HDR)), !frame_closed_o)

  // A stalled result holds until it is taken.
  `VPFA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(frame_number_o))

endmodule

bind video_payload_frame_assembler vpfa_checker u_vpfa_checker (.*);
